/* hw/rtl/decimal_digit_splitter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal digit splitter
// Clocked, reset-qualified property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_SPLITTER_ASSERT_SVH
`define DECIMAL_DIGIT_SPLITTER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define DDS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define DDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// Shared constants, types and the shift-add-3 step of the digit splitter.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Input value width and most digits a run may carry
  localparam int VALUE_BITS      = 32;
  localparam int MAX_DIGIT_COUNT = 10;

  // Binary bits retired by each conversion stage
  localparam int STAGE_BITS = 4;
  localparam int NUM_STAGES = (VALUE_BITS + STAGE_BITS - 1) / STAGE_BITS;
  localparam int PAD_BITS   = NUM_STAGES * STAGE_BITS;

  // Decimal digits needed to hold any input value (77/256 ~ log10(2))
  localparam int BCD_DIGITS = (VALUE_BITS * 77) / 256 + 1;
  localparam int NUM_DIGITS = (BCD_DIGITS > MAX_DIGIT_COUNT) ? BCD_DIGITS : MAX_DIGIT_COUNT;

  // Field widths
  localparam int DIGIT_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int NAT_W     = $clog2(NUM_DIGITS + 1);
  localparam int CNT_W     = (NAT_W > CFG_W) ? NAT_W : CFG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = CFG_IDX_W'(1);

  // Reset values of the registers
  localparam logic [CFG_W-1:0] MAX_DIGITS_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] MIN_WIDTH_RST  = CFG_W'(1);

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // Conversion state: decimal digits above, binary bits still to shift below
  typedef struct packed {
    bcd_t                bcd;
    logic [PAD_BITS-1:0] bin;
  } dabble_t;

  // Register settings seen by the count stage
  typedef struct packed {
    logic [CFG_W-1:0] max_digits;
    logic [CFG_W-1:0] min_width;
  } cfg_t;

  // One run ready to be sent out
  typedef struct packed {
    bcd_t             digits;
    logic [CNT_W-1:0] total;
    logic             count_only;
  } run_t;

  // One shift-add-3 step: correct digits of five or more, then shift left
  function automatic dabble_t dabble_step(input dabble_t d);
    bcd_t    dig;
    dabble_t r;
    dig = d.bcd;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (dig[k] >= DIGIT_W'(5)) begin
        dig[k] = dig[k] + DIGIT_W'(3);
      end
    end
    r = dabble_t'({dig, d.bin} << 1);
    return r;
  endfunction

endpackage

/* hw/rtl/decimal_digit_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_splitter
// Splits an unsigned binary value into a run of decimal digits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on value/value_valid/value_ready. Each request yields a
//   run of digits on digit_valid/digit_ready, most significant digit first,
//   with digit_count repeated on every result and is_last on the final one.
//   With max_digits at zero each request yields a single count-only result.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user must
//   do so only while idle, which the block itself does not enforce.
// Pipeline and throughput:
//   A request passes through 8 shift-add-3 stages of 4 bits each, one count
//   stage and one output stage before its first digit reaches the outputs.
//   The output stage sends one digit per cycle while digit_ready is high, so
//   a request holds it until its run of 1 to 10 digits is taken; the pipeline
//   takes a request per cycle while the output side keeps up.
// Reset and stalls:
//   Reset empties the pipeline and sets max_digits to 10, min_width to 1.
//   When digit_ready is low, the current digit holds and the stages fill up
//   behind it; value_ready drops only once every stage holds a request.
// ----------------------------------------------------------------------------
module decimal_digit_splitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           value_valid,
  output logic                           value_ready,
  input  logic [dds_pkg::VALUE_BITS-1:0] value,
  output logic                           digit_valid,
  input  logic                           digit_ready,
  output logic [dds_pkg::DIGIT_W-1:0]    digit,
  output logic [dds_pkg::COUNT_W-1:0]    digit_count,
  output logic                           count_only,
  output logic                           is_last
);

  dds_pkg::cfg_t                   cfg;
  dds_pkg::dabble_t                stage_data [dds_pkg::NUM_STAGES+1];
  logic [dds_pkg::NUM_STAGES:0]    stage_valid;
  logic [dds_pkg::NUM_STAGES:0]    stage_ready;
  logic                            run_valid;
  logic                            run_ready;
  dds_pkg::run_t                   run_data;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_digits <= dds_pkg::MAX_DIGITS_RST;
      cfg.min_width  <= dds_pkg::MIN_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dds_pkg::REG_MAX_DIGITS: cfg.max_digits <= cfg_data;
        dds_pkg::REG_MIN_WIDTH:  cfg.min_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Feed the value in with cleared digits
  assign stage_valid[0]    = value_valid;
  assign value_ready       = stage_ready[0];
  assign stage_data[0].bcd = '0;
  assign stage_data[0].bin = dds_pkg::PAD_BITS'(value);

  // Conversion pipeline
  for (genvar i = 0; i < dds_pkg::NUM_STAGES; i++) begin : g_stage
    dds_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  dds_count u_count (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (stage_valid[dds_pkg::NUM_STAGES]),
    .in_ready  (stage_ready[dds_pkg::NUM_STAGES]),
    .in_data   (stage_data[dds_pkg::NUM_STAGES]),
    .out_valid (run_valid),
    .out_ready (run_ready),
    .out_data  (run_data)
  );

  dds_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (run_valid),
    .in_ready    (run_ready),
    .in_data     (run_data),
    .out_valid   (digit_valid),
    .out_ready   (digit_ready),
    .digit       (digit),
    .digit_count (digit_count),
    .count_only  (count_only),
    .is_last     (is_last)
  );

endmodule

/* hw/rtl/dds_dabble_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_dabble_stage
// One pipeline stage of the binary to decimal conversion: retires
// STAGE_BITS binary bits per request with the shift-add-3 rule.
// ----------------------------------------------------------------------------
module dds_dabble_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dds_pkg::dabble_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dds_pkg::dabble_t out_data
);

  logic             valid;
  dds_pkg::dabble_t data;
  dds_pkg::dabble_t data_next;

  // Accept when empty or when the held request moves on
  assign in_ready = !valid || out_ready;

  // Run the shift-add-3 steps of this stage
  always_comb begin
    data_next = in_data;
    for (int s = 0; s < dds_pkg::STAGE_BITS; s++) begin
      data_next = dds_pkg::dabble_step(data_next);
    end
  end

  // Hold valid with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* hw/rtl/dds_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_count
// Finds the natural digit count and sizes the run from the maximum-digits
// and minimum-width settings; selects count-only mode.
// ----------------------------------------------------------------------------
module dds_count (
  input  logic             clk,
  input  logic             rst,
  input  dds_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  dds_pkg::dabble_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dds_pkg::run_t    out_data
);

  logic                      valid;
  dds_pkg::run_t             data;
  dds_pkg::run_t             data_next;
  logic [dds_pkg::CNT_W-1:0] nat;
  logic [dds_pkg::CNT_W-1:0] mx;
  logic [dds_pkg::CNT_W-1:0] lim;
  logic [dds_pkg::CNT_W-1:0] n;
  logic [dds_pkg::CNT_W-1:0] w;
  logic [dds_pkg::CNT_W-1:0] tot;

  assign in_ready = !valid || out_ready;

  // Natural count: position of the highest nonzero digit, at least one
  always_comb begin
    nat = dds_pkg::CNT_W'(1);
    for (int k = 0; k < dds_pkg::NUM_DIGITS; k++) begin
      if (in_data.bcd[k] != '0) begin
        nat = dds_pkg::CNT_W'(k + 1);
      end
    end
  end

  // Saturate the limits and size the run
  always_comb begin
    mx  = dds_pkg::CNT_W'(cfg.max_digits);
    lim = (mx > dds_pkg::CNT_W'(dds_pkg::MAX_DIGIT_COUNT)) ?
          dds_pkg::CNT_W'(dds_pkg::MAX_DIGIT_COUNT) : mx;
    n   = (nat < lim) ? nat : lim;
    w   = dds_pkg::CNT_W'(cfg.min_width);
    tot = (n > w) ? n : w;
    if (tot > lim) begin
      tot = lim;
    end
    data_next.digits     = in_data.bcd;
    data_next.count_only = (cfg.max_digits == '0);
    data_next.total      = data_next.count_only ? nat : tot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* hw/rtl/dds_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_serializer
// Holds one run; one digit per cycle unless stalled, most significant first.
// ----------------------------------------------------------------------------
module dds_serializer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dds_pkg::run_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dds_pkg::DIGIT_W-1:0]  digit,
  output logic [dds_pkg::COUNT_W-1:0]  digit_count,
  output logic                         count_only,
  output logic                         is_last
);

  logic                      busy;
  dds_pkg::run_t             run;
  logic [dds_pkg::IDX_W-1:0] pos;
  logic                      last;

  assign last = run.count_only || (pos == '0);

  // Take the next run once the last digit of this one is taken
  assign in_ready = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_ready) begin
      busy <= in_valid;
    end
  end

  // Load a run, then step down through its digits
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      run <= in_data;
      pos <= in_data.count_only ? '0 :
             dds_pkg::IDX_W'(in_data.total - dds_pkg::CNT_W'(1));
    end else if (busy && out_ready && !last) begin
      pos <= pos - dds_pkg::IDX_W'(1);
    end
  end

  assign out_valid   = busy;
  assign digit       = run.count_only ? '0 : run.digits[pos];
  assign digit_count = dds_pkg::COUNT_W'(run.total);
  assign count_only  = run.count_only;
  assign is_last     = last;

endmodule

/* hw/rtl/dds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the digit output channel of the splitter.
// ----------------------------------------------------------------------------
`include "decimal_digit_splitter_assert.svh"

module dds_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          digit_valid,
  input logic                          digit_ready,
  input logic [dds_pkg::DIGIT_W-1:0]   digit,
  input logic [dds_pkg::COUNT_W-1:0]   digit_count,
  input logic                          count_only,
  input logic                          is_last
);

  // A digit is always decimal
  `DDS_ASSERT_NOW(a_digit_decimal, clk, rst, digit_valid, digit <= dds_pkg::DIGIT_W'(9), "digit above nine")

  // A count-only result stands alone
  `DDS_ASSERT_NOW(a_count_only_last, clk, rst, digit_valid && count_only, is_last, "count-only result not last")

  // A run continues without a gap and keeps its length
  `DDS_ASSERT_NEXT(a_run_continues, clk, rst, digit_valid && digit_ready && !is_last, digit_valid && !count_only && digit_count == $past(digit_count), "run broken")

  // A stalled result holds
  `DDS_ASSERT_NEXT(a_stall_holds, clk, rst, digit_valid && !digit_ready, digit_valid && $stable(digit) && $stable(digit_count) && $stable(is_last), "stalled result changed")

endmodule

bind decimal_digit_splitter dds_checker u_checker (.*);
